FILE: hw/rtl/trle_pkg.sv
// ----------------------------------------------------------------------------
// Tile run-length encoder package
// Shared widths, defaults and the run and push records.
// ----------------------------------------------------------------------------
package trle_pkg;

  // Field widths of the ports.
  localparam int WORD_W = 32;
  localparam int LEN_W  = 16;
  localparam int CFG_W  = 21;

  // Defaults for the top-level parameters.
  localparam int MAX_TILES_DEF = 1048576;
  localparam int MAX_RUN_DEF   = 65535;

  // Layer size after reset.
  localparam int RESET_TILES = 1048576;

  // Depth of the result queue; it must hold two beats beyond what drains.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One finished run.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
    logic              last;
  } run_t;

  // Runs produced by one tile, packed toward slot zero.
  typedef struct packed {
    logic v0;
    logic v1;
    run_t r0;
    run_t r1;
  } push_t;

endpackage

FILE: hw/rtl/tile_run_length_encoder.sv
// ----------------------------------------------------------------------------
// Tile run-length encoder
// Turns a stream of tile words into (length, word) runs, one layer at a time.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_ready  | tile_word, end_of_layer
//  out_    | output    | out_valid/out_ready| run_length, run_word, last_run
//  cfg_    | input     | cfg_wr_en          | tiles_per_layer
//
// One tile beat is taken per cycle while the queue has room for two runs; a
// tile waits in the input register until then, and its runs go into the queue.
// A tile that closes two runs puts two beats into the four-entry queue, and
// the output drains one beat per cycle while ready, so such tiles can stall.
// Reset is synchronous; it drops any open run and clears the queue.
// A stall on the output holds tiles in the input register once the queue fills.
// ----------------------------------------------------------------------------
module tile_run_length_encoder #(
  parameter int MAX_TILES = trle_pkg::MAX_TILES_DEF,
  parameter int MAX_RUN   = trle_pkg::MAX_RUN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [trle_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [trle_pkg::WORD_W-1:0] in_tile_word,
  input  logic                        in_end_of_layer,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [trle_pkg::LEN_W-1:0]  out_run_length,
  output logic [trle_pkg::WORD_W-1:0] out_run_word,
  output logic                        out_last_run
);

  logic            push_ok;
  logic            push_en;
  trle_pkg::push_t push;

  // Run detection and layer counting.
  trle_core #(
    .MAX_TILES (MAX_TILES),
    .MAX_RUN   (MAX_RUN)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_tile_word    (in_tile_word),
    .in_end_of_layer (in_end_of_layer),
    .push_ok         (push_ok),
    .push_en         (push_en),
    .push            (push)
  );

  // Result queue toward the output channel.
  trle_fifo u_fifo (
    .clk            (clk),
    .rst_n          (rst_n),
    .push_en        (push_en),
    .push           (push),
    .push_ok        (push_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_run_length (out_run_length),
    .out_run_word   (out_run_word),
    .out_last_run   (out_last_run)
  );

endmodule

FILE: hw/rtl/trle_core.sv
// ----------------------------------------------------------------------------
// Tile run-length encoder core
// Input register, open-run state and the compare/increment that closes runs.
// ----------------------------------------------------------------------------
module trle_core #(
  parameter int MAX_TILES = trle_pkg::MAX_TILES_DEF,
  parameter int MAX_RUN   = trle_pkg::MAX_RUN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [trle_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [trle_pkg::WORD_W-1:0] in_tile_word,
  input  logic                       in_end_of_layer,
  input  logic                       push_ok,
  output logic                       push_en,
  output trle_pkg::push_t            push
);

  localparam int CW    = $clog2(MAX_TILES + 1);
  localparam int RW    = $clog2(MAX_RUN + 1);
  localparam int CMP_W = (CW > trle_pkg::CFG_W) ? CW : trle_pkg::CFG_W;
  localparam int RST_T = (trle_pkg::RESET_TILES > MAX_TILES) ? MAX_TILES
                                                             : trle_pkg::RESET_TILES;
  localparam logic [CMP_W-1:0] MAX_T  = CMP_W'(MAX_TILES);
  localparam logic [RW-1:0]    RUN_MX = RW'(MAX_RUN);

  // Input stage.
  logic                        stg_vld_r;
  logic [trle_pkg::WORD_W-1:0] stg_word_r;
  logic                        stg_eol_r;
  logic                        go;

  // Layer size, open run and tile count.
  logic [CMP_W-1:0]            total_r, total_nxt;
  logic [RW-1:0]               cnt_r, cnt_nxt;
  logic [trle_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [CW-1:0]               cons_r, cons_nxt;

  // Datapath terms.
  logic                        change;
  logic                        fresh;
  logic [RW-1:0]               new_cnt;
  logic [trle_pkg::WORD_W-1:0] new_word;
  logic [CW-1:0]               cons_inc;
  logic                        layer_end;
  logic                        full;
  logic                        emit2;
  logic [CMP_W-1:0]            cfg_ext;

  assign go       = stg_vld_r && push_ok;
  assign in_ready = !stg_vld_r || push_ok;
  assign push_en  = go;

  // Clamp the written layer size to the range one to MAX_TILES.
  always_comb begin
    cfg_ext = CMP_W'(cfg_wr_data);
    if (cfg_ext == '0) begin
      total_nxt = CMP_W'(1);
    end else if (cfg_ext > MAX_T) begin
      total_nxt = MAX_T;
    end else begin
      total_nxt = cfg_ext;
    end
  end

  // Extend or close the open run for the tile in the input stage.
  always_comb begin
    change    = (cnt_r != '0) && (stg_word_r != word_r);
    fresh     = (cnt_r == '0) || change;
    new_cnt   = (fresh ? '0 : cnt_r) + RW'(1);
    new_word  = fresh ? stg_word_r : word_r;
    cons_inc  = cons_r + CW'(1);
    layer_end = stg_eol_r || (CMP_W'(cons_inc) >= total_r);
    full      = (new_cnt >= RUN_MX);
    emit2     = layer_end || full;

    // The old run goes first; the run of the new word follows when it closes.
    push.r0.len  = change ? trle_pkg::LEN_W'(cnt_r) : trle_pkg::LEN_W'(new_cnt);
    push.r0.word = change ? word_r : new_word;
    push.r0.last = change ? 1'b0 : layer_end;
    push.r1.len  = trle_pkg::LEN_W'(new_cnt);
    push.r1.word = new_word;
    push.r1.last = layer_end;
    push.v0      = change || emit2;
    push.v1      = change && emit2;

    if (layer_end) begin
      cnt_nxt  = '0;
      word_nxt = '0;
      cons_nxt = '0;
    end else if (full) begin
      cnt_nxt  = '0;
      word_nxt = new_word;
      cons_nxt = cons_inc;
    end else begin
      cnt_nxt  = new_cnt;
      word_nxt = new_word;
      cons_nxt = cons_inc;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      total_r   <= CMP_W'(RST_T);
      cnt_r     <= '0;
      word_r    <= '0;
      cons_r    <= '0;
    end else begin
      if (in_ready) begin
        stg_vld_r <= in_valid;
      end
      if (cfg_wr_en) begin
        total_r <= total_nxt;
      end
      if (go) begin
        cnt_r  <= cnt_nxt;
        word_r <= word_nxt;
        cons_r <= cons_nxt;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_word_r <= in_tile_word;
      stg_eol_r  <= in_end_of_layer;
    end
  end

endmodule

FILE: hw/rtl/trle_fifo.sv
// ----------------------------------------------------------------------------
// Tile run-length encoder result queue
// Takes up to two runs a cycle with room; gives one beat a cycle while ready.
// ----------------------------------------------------------------------------
module trle_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_en,
  input  trle_pkg::push_t             push,
  output logic                        push_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [trle_pkg::LEN_W-1:0]  out_run_length,
  output logic [trle_pkg::WORD_W-1:0] out_run_word,
  output logic                        out_last_run
);

  trle_pkg::run_t                 mem [trle_pkg::FIFO_DEPTH];
  logic [trle_pkg::FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [trle_pkg::FIFO_CW-1:0]   count_r, count_nxt;
  logic                           pop;
  logic                           wr0, wr1;
  logic [trle_pkg::FIFO_CW-1:0]   space;
  logic [trle_pkg::FIFO_AW-1:0]   wr_ptr1;
  trle_pkg::run_t                 head;

  assign pop   = out_valid && out_ready;
  assign wr0   = push_en && push.v0;
  assign wr1   = push_en && push.v1;
  assign space = trle_pkg::FIFO_CW'(trle_pkg::FIFO_DEPTH) - count_r
               + trle_pkg::FIFO_CW'(pop);

  // Room for the worst case of two runs, counting the beat leaving now.
  assign push_ok   = (space >= trle_pkg::FIFO_CW'(2));
  assign out_valid = (count_r != '0);
  assign wr_ptr1   = wr_ptr_r + trle_pkg::FIFO_AW'(1);

  assign head           = mem[rd_ptr_r];
  assign out_run_length = head.len;
  assign out_run_word   = head.word;
  assign out_last_run   = head.last;

  always_comb begin
    count_nxt = count_r + trle_pkg::FIFO_CW'(wr0) + trle_pkg::FIFO_CW'(wr1)
              - trle_pkg::FIFO_CW'(pop);
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + trle_pkg::FIFO_AW'(1);
      end
      if (wr1) begin
        wr_ptr_r <= wr_ptr_r + trle_pkg::FIFO_AW'(2);
      end else if (wr0) begin
        wr_ptr_r <= wr_ptr1;
      end
    end
  end

  // Storage writes.
  always_ff @(posedge clk) begin
    if (wr0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (wr1) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

endmodule

FILE: hw/rtl/trle_checker.sv
// ----------------------------------------------------------------------------
// Tile run-length encoder port checker
// Watches the top-level ports and flags broken output behavior.
// ----------------------------------------------------------------------------
module trle_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [trle_pkg::LEN_W-1:0]  out_run_length,
  input logic [trle_pkg::WORD_W-1:0] out_run_word,
  input logic                        out_last_run
);

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_run_length)
      && $stable(out_run_word) && $stable(out_last_run))
    else $error("output beat changed while stalled");

  // Every run holds at least one tile.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != '0)
    else $error("run of length zero");

  // An output beat after an empty queue comes from an earlier input tile.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output beat without an input tile");

endmodule

bind tile_run_length_encoder trle_checker u_trle_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_run_length (out_run_length),
  .out_run_word   (out_run_word),
  .out_last_run   (out_last_run)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile run-length encoder testbench
// Drives tile beats through the encoder under several layer sizes and idle
// patterns, predicts every run beat in software and checks each one in order.
// ----------------------------------------------------------------------------

// Predicts the run beats of the encoder and checks the beats it emits.
class run_predictor;
  logic [trle_pkg::CFG_W-1:0]  layer_size;
  logic [trle_pkg::WORD_W-1:0] open_word;
  int unsigned                 open_len;
  int unsigned                 layer_count;
  trle_pkg::run_t              pending_runs[$];
  int                          failures;
  int                          runs_seen;

  function new();
    layer_size  = trle_pkg::RESET_TILES;
    open_word   = '0;
    open_len    = 0;
    layer_count = 0;
    failures    = 0;
    runs_seen   = 0;
  endfunction

  function void set_layer_size(logic [trle_pkg::CFG_W-1:0] size);
    layer_size = size;
  endfunction

  function int pending();
    return pending_runs.size();
  endfunction

  function void queue_run(int unsigned len, logic [trle_pkg::WORD_W-1:0] word, logic last);
    trle_pkg::run_t r;
    r.len  = len[trle_pkg::LEN_W-1:0];
    r.word = word;
    r.last = last;
    pending_runs = {pending_runs, r};
  endfunction

  // Work out the runs that one accepted tile beat closes.
  function void take_tile(logic [trle_pkg::WORD_W-1:0] word, logic eol);
    int unsigned total;
    total = layer_size;
    if (total == 0)
      total = 1;
    if (total > trle_pkg::MAX_TILES_DEF)
      total = trle_pkg::MAX_TILES_DEF;

    // A new word closes the open run first.
    if (open_len != 0 && word != open_word) begin
      queue_run(open_len, open_word, 1'b0);
      open_len = 0;
    end
    if (open_len == 0)
      open_word = word;
    open_len++;
    layer_count++;

    // End of layer wins over a full run, so a full closing run goes out once.
    if (eol || layer_count >= total) begin
      queue_run(open_len, open_word, 1'b1);
      open_len    = 0;
      open_word   = '0;
      layer_count = 0;
    end else if (open_len >= trle_pkg::MAX_RUN_DEF) begin
      queue_run(open_len, open_word, 1'b0);
      open_len = 0;
    end
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10)
      $display("%s", msg);
  endfunction

  // Compare one run beat from the encoder with the oldest prediction.
  function void check_run(trle_pkg::run_t got);
    trle_pkg::run_t want;
    runs_seen++;
    if (pending_runs.size() == 0) begin
      note_failure($sformatf("run %0d unexpected: len %0d word %h last %0d",
                             runs_seen, got.len, got.word, got.last));
      return;
    end
    want = pending_runs.pop_front();
    if (got.len !== want.len || got.word !== want.word || got.last !== want.last)
      note_failure($sformatf(
        "run %0d mismatch: expected len %0d word %h last %0d, got len %0d word %h last %0d",
        runs_seen, want.len, want.word, want.last, got.len, got.word, got.last));
  endfunction

  function void close_out();
    if (pending_runs.size() != 0)
      note_failure($sformatf("%0d predicted runs never arrived", pending_runs.size()));
  endfunction
endclass

module tb_top;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_TILES = 38;

  logic                        clk             = 1'b0;
  logic                        rst_n           = 1'b0;
  logic                        cfg_wr_en       = 1'b0;
  logic [trle_pkg::CFG_W-1:0]  cfg_wr_data     = '0;
  logic                        in_valid        = 1'b0;
  logic                        in_ready;
  logic [trle_pkg::WORD_W-1:0] in_tile_word    = '0;
  logic                        in_end_of_layer = 1'b0;
  logic                        out_valid;
  logic                        out_ready       = 1'b0;
  logic [trle_pkg::LEN_W-1:0]  out_run_length;
  logic [trle_pkg::WORD_W-1:0] out_run_word;
  logic                        out_last_run;

  run_predictor   runs;
  trle_pkg::run_t seen_run;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             hold_requests = 0;
  int             hold_served   = 0;
  int             hold_left     = 0;
  int             stall_cycles  = 0;

  tile_run_length_encoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_tile_word    (in_tile_word),
    .in_end_of_layer (in_end_of_layer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_run_length  (out_run_length),
    .out_run_word    (out_run_word),
    .out_last_run    (out_last_run)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check each accepted run beat, then pick the next ready.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      seen_run.len  = out_run_length;
      seen_run.word = out_run_word;
      seen_run.last = out_last_run;
      runs.check_run(seen_run);
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one tile beat, with random idle cycles ahead of it, and wait until
  // it is taken.
  task automatic send_tile(input logic [trle_pkg::WORD_W-1:0] word, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_tile_word    <= word;
    in_end_of_layer <= eol;
    do
      @(posedge clk);
    while (in_ready !== 1'b1);
    runs.take_tile(word, eol);
  endtask

  // Stop offering tiles and wait until the encoder has drained.
  task automatic drain();
    in_valid <= 1'b0;
    while (runs.pending() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the layer size while the encoder is idle.
  task automatic set_layer_size(input logic [trle_pkg::CFG_W-1:0] size);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    runs.set_layer_size(size);
  endtask

  function automatic logic [trle_pkg::CFG_W-1:0] pick_layer_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 21'd1;
      2:       return 21'd2;
      3:       return trle_pkg::CFG_W'($urandom_range(3, 8));
      4:       return trle_pkg::CFG_W'($urandom_range(9, 64));
      5:       return 21'h100000;
      6:       return 21'h1FFFFF;
      7:       return trle_pkg::CFG_W'($urandom());
      default: return trle_pkg::CFG_W'($urandom_range(3, 30));
    endcase
  endfunction

  // Words from a small set repeat often, so runs merge and split.
  function automatic logic [trle_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return '0;
      2:       return '1;
      default: return trle_pkg::WORD_W'($urandom_range(0, 3));
    endcase
  endfunction

  // Mostly runs of equal words with random length, some single noise tiles.
  task automatic send_tile_runs(input int count);
    int                          sent;
    int                          len;
    int                          k;
    logic [trle_pkg::WORD_W-1:0] word;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send_tile($urandom(), 1'($urandom_range(1)));
        sent++;
      end else begin
        word = pick_word();
        len  = ($urandom_range(7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          send_tile(word, ($urandom_range(99) < 3) ||
                          (k == len - 1 && $urandom_range(9) == 0));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int phase;
    int seg;
    int k;

    runs = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 15;
    recv_idle_pct <= 55;

    // Reset layer size: runs close on a word change or on end_of_layer.
    repeat (3) send_tile('0, 1'b0);
    send_tile('1, 1'b0);
    send_tile('1, 1'b1);
    send_tile(32'hA5A5_5A5A, 1'b1);
    // A word change on the closing tile gives two beats from one tile.
    send_tile(32'd1, 1'b0);
    send_tile(32'd2, 1'b1);

    // A layer size of zero behaves as one tile per layer.
    set_layer_size('0);
    send_tile(32'd7, 1'b0);
    send_tile(32'd7, 1'b0);

    // Three-tile layers, then leave one tile of a layer open.
    set_layer_size(21'd3);
    repeat (4) send_tile(32'd5, 1'b0);
    send_tile(32'd6, 1'b0);
    send_tile(32'd6, 1'b0);
    send_tile(32'd9, 1'b0);

    // Shrinking the size below the count taken closes the layer on the next tile.
    set_layer_size(21'd1);
    send_tile(32'd9, 1'b0);

    // Sizes above the maximum are clipped.
    set_layer_size(21'h1FFFFF);
    send_tile(32'h8000_0001, 1'b0);
    send_tile(32'h7FFF_FFFE, 1'b1);

    // Random runs under three idle patterns, new layer size per segment.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct <= 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct <= 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (seg = 0; seg < SEGMENTS; seg++) begin
        set_layer_size(pick_layer_size());
        send_tile_runs(SEGMENT_TILES);
      end
    end

    // Long receiver stall while tiles keep coming, so the queue fills up.
    hold_requests <= hold_requests + 1;
    for (k = 0; k < 60; k++)
      send_tile($urandom(), 1'b0);

    drain();
    runs.close_out();
    if (runs.failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
